FILE: rtl/core/pct_pkg.sv
// Shared types and constants for the pointer cursor tracker.
// Used by pct_divider and pointer_cursor_tracker; depends on nothing else.
package pct_pkg;

  // Default width of the stored cursor position.
  localparam int PCT_POSITION_BITS = 12;

  // Field widths.
  localparam int PCT_SIZE_BITS  = 12;
  localparam int PCT_SPEED_BITS = 8;
  localparam int PCT_COORD_BITS = 16;
  localparam int PCT_OUT_BITS   = 12;

  // Stream and register port widths.
  localparam int PCT_IN_DATA_BITS  = 136;
  localparam int PCT_OUT_DATA_BITS = 32;
  localparam int PCT_ADDR_BITS     = 4;
  localparam int PCT_APB_BITS      = 32;

  // Serial divider: numerator sized for coord*size, denominator a 16-bit device value.
  localparam int PCT_NUM_BITS = PCT_COORD_BITS + PCT_SIZE_BITS;
  localparam int PCT_DEN_BITS = PCT_COORD_BITS;
  localparam int PCT_CNT_BITS = $clog2(PCT_NUM_BITS + 1);

  // Register reset values.
  localparam logic [PCT_SIZE_BITS-1:0]  PCT_RESET_WIDTH  = 12'd1024;
  localparam logic [PCT_SIZE_BITS-1:0]  PCT_RESET_HEIGHT = 12'd768;
  localparam logic [PCT_SPEED_BITS-1:0] PCT_RESET_SPEED  = 8'd4;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_ABS      = 2'd1,
    CMD_REL      = 2'd2,
    CMD_RECENTER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SPEED  = 2'd2,
    REG_AVAIL  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pct_div_stat_t;

endpackage

FILE: rtl/core/pct_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pct_pkg for widths and the status struct.
module pct_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [pct_pkg::PCT_NUM_BITS-1:0]   num,
  input  logic [pct_pkg::PCT_DEN_BITS-1:0]   den,
  output logic [pct_pkg::PCT_NUM_BITS-1:0]   quo,
  output pct_pkg::pct_div_stat_t             stat
);
  import pct_pkg::*;

  logic [PCT_NUM_BITS-1:0] quo_sr;
  logic [PCT_DEN_BITS-1:0] rem;
  logic [PCT_DEN_BITS-1:0] den_r;
  logic [PCT_CNT_BITS-1:0] count;
  logic                    busy;
  logic                    done;

  logic [PCT_DEN_BITS:0]   rem_sh;
  logic [PCT_DEN_BITS:0]   diff;
  logic                    fits;
  logic [PCT_DEN_BITS-1:0] rem_next;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh   = {rem, quo_sr[PCT_NUM_BITS-1]};
    diff     = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
    rem_next = fits ? diff[PCT_DEN_BITS-1:0] : rem_sh[PCT_DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= PCT_CNT_BITS'(PCT_NUM_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == PCT_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sr <= num;
      rem    <= '0;
      den_r  <= den;
    end else if (busy) begin
      quo_sr <= {quo_sr[PCT_NUM_BITS-2:0], fits};
      rem    <= rem_next;
    end
  end

  assign quo       = quo_sr;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/core/pointer_cursor_tracker.sv
// Pointer cursor tracker: a report is accepted only in the idle state. With a pointer
// available, absolute and relative reports then run each axis, x then y, through a
// multiply state, the divider steps with its done flag and a fix-up state, then reach
// the output state; other rounds go there straight. No new report is taken until the
// result is registered, and a stalled result holds off the next report.
// Synchronous active-high reset restores the registers and recenters on the default screen.
module pointer_cursor_tracker #(
  parameter int POSITION_BITS = pct_pkg::PCT_POSITION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Register port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pct_pkg::PCT_ADDR_BITS-1:0]      paddr,
  input  logic [pct_pkg::PCT_APB_BITS-1:0]       pwdata,
  output logic [pct_pkg::PCT_APB_BITS-1:0]       prdata,
  output logic                                   pready,
  // Report requests. tdata from bit 0: abs_x, abs_y, abs_max_x, abs_max_y,
  // touch_active, rel_dx, rel_dy, res_x, res_y, left_button, zero fill.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [pct_pkg::PCT_IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: command.
  input  logic [1:0]                             s_axis_tuser,
  // Result requests. tdata from bit 0: cursor_x, cursor_y, holding, press, zero fill.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [pct_pkg::PCT_OUT_DATA_BITS-1:0]  m_axis_tdata,
  // tuser: status.
  output logic [0:0]                             m_axis_tuser
);
  import pct_pkg::*;

  localparam logic [PCT_NUM_BITS-1:0] PosMax =
    PCT_NUM_BITS'((64'd1 << POSITION_BITS) - 64'd1);

  // Saturate a wide value to the position width.
  function automatic logic [POSITION_BITS-1:0] fit_pos(input logic [PCT_NUM_BITS-1:0] v);
    logic [POSITION_BITS-1:0] r;
    if (v > PosMax) r = '1;
    else            r = v[POSITION_BITS-1:0];
    return r;
  endfunction

  // The result carries only the low 12 bits of a position.
  function automatic logic [PCT_OUT_BITS-1:0] out_pos(input logic [POSITION_BITS-1:0] p);
    logic [PCT_NUM_BITS-1:0] w;
    w = PCT_NUM_BITS'(p);
    return w[PCT_OUT_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [PCT_SIZE_BITS-1:0]  screen_width;
  logic [PCT_SIZE_BITS-1:0]  screen_height;
  logic [PCT_SPEED_BITS-1:0] mouse_speed;
  logic                      pointer_available;

  // Tracker state.
  logic [POSITION_BITS-1:0] pos_x, pos_y;
  logic                     held, pressed;

  // Captured report.
  cmd_t                      cmd;
  logic [PCT_COORD_BITS-1:0] abs_x, abs_y, abs_max_x, abs_max_y;
  logic                      touch_active;
  logic [PCT_COORD_BITS-1:0] rel_dx, rel_dy;
  logic [PCT_COORD_BITS-1:0] res_x, res_y;
  logic                      left_button;

  state_t state;
  logic   axis;  // 0 works on x, 1 on y
  logic [POSITION_BITS-1:0] new_x, new_y;

  // APB: always ready; a write lands when the access phase completes.
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = PCT_APB_BITS'(screen_width);
      REG_HEIGHT: prdata = PCT_APB_BITS'(screen_height);
      REG_SPEED:  prdata = PCT_APB_BITS'(mouse_speed);
      REG_AVAIL:  prdata = PCT_APB_BITS'(pointer_available);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width      <= PCT_RESET_WIDTH;
      screen_height     <= PCT_RESET_HEIGHT;
      mouse_speed       <= PCT_RESET_SPEED;
      pointer_available <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  screen_width      <= pwdata[PCT_SIZE_BITS-1:0];
        REG_HEIGHT: screen_height     <= pwdata[PCT_SIZE_BITS-1:0];
        REG_SPEED:  mouse_speed       <= pwdata[PCT_SPEED_BITS-1:0];
        REG_AVAIL:  pointer_available <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // Per-axis operand selection for the shared multiply and divider.
  logic [PCT_SIZE_BITS-1:0]  sel_size;
  logic [POSITION_BITS-1:0]  sel_pos;
  logic [PCT_COORD_BITS-1:0] sel_coord, sel_max, sel_dx, sel_res;
  logic                      dx_neg;
  logic [PCT_COORD_BITS-1:0] dx_mag;
  logic [PCT_NUM_BITS-1:0]   prod_abs;
  logic [PCT_NUM_BITS-1:0]   prod_rel;
  logic [PCT_NUM_BITS-1:0]   div_num;
  logic [PCT_DEN_BITS-1:0]   div_den;
  logic                      div_start;
  logic [PCT_NUM_BITS-1:0]   div_quo;
  pct_div_stat_t             div_stat;

  always_comb begin
    sel_size  = axis ? screen_height : screen_width;
    sel_pos   = axis ? pos_y : pos_x;
    sel_coord = axis ? abs_y : abs_x;
    sel_max   = axis ? abs_max_y : abs_max_x;
    sel_dx    = axis ? rel_dy : rel_dx;
    sel_res   = axis ? res_y : res_x;
    // Work on the magnitude; the quotient gets its sign back afterward, which
    // gives truncation toward zero. The most negative value maps to 0x8000.
    dx_neg    = sel_dx[PCT_COORD_BITS-1];
    dx_mag    = dx_neg ? (~sel_dx + 1'b1) : sel_dx;
    prod_abs  = PCT_NUM_BITS'(sel_coord) * PCT_NUM_BITS'(sel_size);
    prod_rel  = PCT_NUM_BITS'(dx_mag) * PCT_NUM_BITS'(mouse_speed);
    div_num   = (cmd == CMD_ABS) ? prod_abs : prod_rel;
    div_den   = (cmd == CMD_ABS) ? sel_max : sel_res;
    div_start = (state == ST_MUL);
  end

  pct_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Fix-up after the divide: zero divisor, saturation of absolute values,
  // and clamping of relative moves to the screen.
  logic [PCT_SIZE_BITS-1:0]       size_top;
  logic                           den_zero;
  logic [PCT_NUM_BITS-1:0]        abs_res;
  logic signed [PCT_NUM_BITS:0]   rel_off;
  logic signed [PCT_NUM_BITS:0]   rel_sum;
  logic [PCT_NUM_BITS-1:0]        rel_res;
  logic [POSITION_BITS-1:0]       axis_new;

  always_comb begin
    size_top = (sel_size == '0) ? '0 : sel_size - 1'b1;
    den_zero = (div_den == '0);

    if (den_zero)                                abs_res = '0;
    else if (div_quo >= PCT_NUM_BITS'(sel_size)) abs_res = PCT_NUM_BITS'(size_top);
    else                                         abs_res = div_quo;

    if (den_zero)    rel_off = '0;
    else if (dx_neg) rel_off = -$signed({1'b0, div_quo});
    else             rel_off = $signed({1'b0, div_quo});
    rel_sum = $signed({1'b0, PCT_NUM_BITS'(sel_pos)}) + rel_off;

    if (rel_sum < 0)
      rel_res = '0;
    else if (rel_sum >= $signed({1'b0, PCT_NUM_BITS'(sel_size)}))
      rel_res = PCT_NUM_BITS'(size_top);
    else
      rel_res = rel_sum[PCT_NUM_BITS-1:0];

    axis_new = fit_pos((cmd == CMD_ABS) ? abs_res : rel_res);
  end

  // Next tracker state when the round closes.
  logic [POSITION_BITS-1:0] pos_x_next, pos_y_next;
  logic                     held_next, pressed_next, status_next;

  always_comb begin
    pos_x_next   = pos_x;
    pos_y_next   = pos_y;
    held_next    = held;
    pressed_next = pressed;
    status_next  = 1'b1;
    if (cmd == CMD_RECENTER) begin
      pos_x_next   = fit_pos(PCT_NUM_BITS'(screen_width[PCT_SIZE_BITS-1:1]));
      pos_y_next   = fit_pos(PCT_NUM_BITS'(screen_height[PCT_SIZE_BITS-1:1]));
      held_next    = 1'b0;
      pressed_next = 1'b0;
      status_next  = 1'b0;
    end else if (pointer_available) begin
      if (cmd == CMD_ABS || cmd == CMD_REL) begin
        pos_x_next  = new_x;
        pos_y_next  = new_y;
        held_next   = (cmd == CMD_ABS) ? touch_active : left_button;
        status_next = 1'b0;
      end
      // Press marks a release: held before the round and not after it.
      pressed_next = held & ~held_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer: capture the report, run x then y through the divider (absolute and relative
  // reports with a pointer only), then hand the result to the output register once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      axis          <= 1'b0;
      pos_x         <= fit_pos(PCT_NUM_BITS'(PCT_RESET_WIDTH[PCT_SIZE_BITS-1:1]));
      pos_y         <= fit_pos(PCT_NUM_BITS'(PCT_RESET_HEIGHT[PCT_SIZE_BITS-1:1]));
      held          <= 1'b0;
      pressed       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            axis <= 1'b0;
            if (pointer_available && (cmd_t'(s_axis_tuser) == CMD_ABS ||
                                      cmd_t'(s_axis_tuser) == CMD_REL)) begin
              state <= ST_MUL;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) state <= ST_FIX;
        end
        ST_FIX: begin
          if (axis) begin
            state <= ST_OUT;
          end else begin
            axis  <= 1'b1;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            pos_x   <= pos_x_next;
            pos_y   <= pos_y_next;
            held    <= held_next;
            pressed <= pressed_next;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // A new result is loaded as the previous one leaves; otherwise tvalid drops
      // on its handshake.
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd          <= cmd_t'(s_axis_tuser);
      abs_x        <= s_axis_tdata[15:0];
      abs_y        <= s_axis_tdata[31:16];
      abs_max_x    <= s_axis_tdata[47:32];
      abs_max_y    <= s_axis_tdata[63:48];
      touch_active <= s_axis_tdata[64];
      rel_dx       <= s_axis_tdata[80:65];
      rel_dy       <= s_axis_tdata[96:81];
      res_x        <= s_axis_tdata[112:97];
      res_y        <= s_axis_tdata[128:113];
      left_button  <= s_axis_tdata[129];
    end
    if (state == ST_FIX) begin
      if (axis) new_y <= axis_new;
      else      new_x <= axis_new;
    end
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {6'd0, pressed_next, held_next,
                       out_pos(pos_y_next), out_pos(pos_x_next)};
      m_axis_tuser <= status_next;
    end
  end

endmodule

FILE: dv/pointer_cursor_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the pointer cursor tracker: watches the register port and both streams,
// keeps its own copy of the cursor state and compares each result request. Needs pct_pkg.
module pointer_cursor_checker
  import pct_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [PCT_ADDR_BITS-1:0]      paddr,
  input  logic [PCT_APB_BITS-1:0]       pwdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata from bit 0: abs_x, abs_y, abs_max_x, abs_max_y, touch_active, rel_dx, rel_dy,
  // res_x, res_y, left_button, zero fill.
  input  logic [PCT_IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: command.
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: cursor_x, cursor_y, holding, press, zero fill.
  input  logic [PCT_OUT_DATA_BITS-1:0]  m_axis_tdata,
  // tuser: status.
  input  logic [0:0]                    m_axis_tuser,
  output int                            errors,
  output int                            pending
);

  // Report request as it lies in tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic [5:0]  fill;
    logic        left_button;
    logic [15:0] res_y;
    logic [15:0] res_x;
    logic [15:0] rel_dy;
    logic [15:0] rel_dx;
    logic        touch_active;
    logic [15:0] abs_max_y;
    logic [15:0] abs_max_x;
    logic [15:0] abs_y;
    logic [15:0] abs_x;
  } report_t;

  typedef struct packed {
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
    logic        holding;
    logic        press;
    logic        status;
  } cursor_state_t;

  logic [11:0] scr_w, scr_h;
  logic [7:0]  move_gain;
  logic        ptr_present;
  logic [11:0] pos_x, pos_y;
  logic        held, pressed;

  cursor_state_t expected_cursor_q[$];
  int            results_seen;

  function automatic logic [11:0] last_pixel(logic [11:0] size);
    return (size == 12'd0) ? 12'd0 : size - 12'd1;
  endfunction

  function automatic void center_cursor();
    pos_x   = scr_w >> 1;
    pos_y   = scr_h >> 1;
    held    = 1'b0;
    pressed = 1'b0;
  endfunction

  // Touch coordinate scaled to the screen; an out-of-range result sticks at the edge.
  function automatic logic [11:0] scale_touch(logic [15:0] coord, logic [11:0] size,
                                              logic [15:0] extent);
    logic [27:0] quot;
    if (extent == 16'd0) return 12'd0;
    quot = (coord * size) / extent;
    if (quot >= size) return last_pixel(size);
    return quot[11:0];
  endfunction

  // Mouse movement: signed division truncates toward zero, then the sum is clamped.
  function automatic logic [11:0] move_mouse(logic [11:0] pos, logic signed [15:0] delta,
                                             logic [15:0] res, logic [11:0] size);
    longint mv, gain, div, off, sum;
    mv   = delta;
    gain = move_gain;
    div  = res;
    off  = 0;
    if (div != 0) off = (mv * gain) / div;
    sum = pos;
    sum = sum + off;
    if (sum < 0) return 12'd0;
    if (sum >= size) return last_pixel(size);
    return sum[11:0];
  endfunction

  function automatic cursor_state_t advance_cursor(cmd_t cmd, report_t rep);
    cursor_state_t res;
    logic          was_held;
    res.status = 1'b1;
    if (cmd == CMD_RECENTER) begin
      center_cursor();
      res.status = 1'b0;
    end else if (ptr_present) begin
      was_held = held;
      if (cmd == CMD_ABS) begin
        pos_x      = scale_touch(rep.abs_x, scr_w, rep.abs_max_x);
        pos_y      = scale_touch(rep.abs_y, scr_h, rep.abs_max_y);
        held       = rep.touch_active;
        res.status = 1'b0;
      end else if (cmd == CMD_REL) begin
        pos_x      = move_mouse(pos_x, rep.rel_dx, rep.res_x, scr_w);
        pos_y      = move_mouse(pos_y, rep.rel_dy, rep.res_y, scr_h);
        held       = rep.left_button;
        res.status = 1'b0;
      end
      pressed = was_held && !held;
    end
    res.cursor_x = pos_x;
    res.cursor_y = pos_y;
    res.holding  = held;
    res.press    = pressed;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s is %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    cursor_state_t want;
    if (rst) begin
      scr_w       = PCT_RESET_WIDTH;
      scr_h       = PCT_RESET_HEIGHT;
      move_gain   = PCT_RESET_SPEED;
      ptr_present = 1'b0;
      center_cursor();
      expected_cursor_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_WIDTH:  scr_w       = pwdata[11:0];
          REG_HEIGHT: scr_h       = pwdata[11:0];
          REG_SPEED:  move_gain   = pwdata[7:0];
          REG_AVAIL:  ptr_present = pwdata[0];
          default: ;
        endcase
      end
      // A result can never belong to a request taken in the same cycle, so pop first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cursor_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = expected_cursor_q.pop_front();
          check_field("cursor_x", m_axis_tdata[11:0], want.cursor_x);
          check_field("cursor_y", m_axis_tdata[23:12], want.cursor_y);
          check_field("holding", m_axis_tdata[24], want.holding);
          check_field("press", m_axis_tdata[25], want.press);
          check_field("status", m_axis_tuser[0], want.status);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_cursor_q.push_back(advance_cursor(cmd_t'(s_axis_tuser),
                                                   report_t'(s_axis_tdata)));
      pending = expected_cursor_q.size();
    end
  end

endmodule

FILE: dv/pointer_cursor_tracker_test.sv
`timescale 1ns / 100ps
// Top of the pointer cursor tracker testbench: clock, reset, register writes, report
// requests, result back-pressure and the verdict. Needs pct_pkg and pointer_cursor_checker.
module pointer_cursor_tracker_test;
  import pct_pkg::*;

  // No handshake of any kind for this many cycles means the block has hung. The limit
  // leaves a wide margin over the slowest report and any random stall.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet time after the last result, a little over one full report.
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_PHASES  = 10;

  logic                          clk;
  logic                          rst;
  logic                          psel, penable, pwrite;
  logic [PCT_ADDR_BITS-1:0]      paddr;
  logic [PCT_APB_BITS-1:0]       pwdata;
  logic [PCT_APB_BITS-1:0]       prdata;
  logic                          pready;
  logic                          s_axis_tvalid, s_axis_tready;
  // tdata from bit 0: abs_x, abs_y, abs_max_x, abs_max_y, touch_active, rel_dx, rel_dy,
  // res_x, res_y, left_button, zero fill.
  logic [PCT_IN_DATA_BITS-1:0]   s_axis_tdata;
  // tuser: command.
  logic [1:0]                    s_axis_tuser;
  logic                          m_axis_tvalid, m_axis_tready;
  // tdata from bit 0: cursor_x, cursor_y, holding, press, zero fill.
  logic [PCT_OUT_DATA_BITS-1:0]  m_axis_tdata;
  // tuser: status.
  logic [0:0]                    m_axis_tuser;

  int errors, pending;

  // While calm is set neither side inserts idle cycles.
  logic calm;
  logic ptr_on;
  int   sent_by_cmd[4];
  int   settings_made;
  int   results_taken;
  int   quiet_cycles;

  pointer_cursor_tracker dut (.*);

  pointer_cursor_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: drop tready with a chance of 29 percent, never while calm.
  always @(negedge clk)
    m_axis_tready <= calm || ($urandom_range(99) >= 29);

  // Watchdog and result count. Any accepted request, result or register access counts as
  // progress.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) results_taken++;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still due",
               quiet_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PCT_IN_DATA_BITS-1:0] pack_report(
      input logic [15:0] ax, ay, amx, amy, input logic touch,
      input logic [15:0] dx, dy, rx, ry, input logic lb);
    return {6'd0, lb, ry, rx, dy, dx, touch, amy, amx, ay, ax};
  endfunction

  // Device extents: mostly arbitrary, with zero, full scale and small ranges mixed in.
  function automatic logic [15:0] pick_extent();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(255, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // A touch coordinate, usually inside the extent so the cursor lands across the screen.
  function automatic logic [15:0] pick_coord(logic [15:0] extent);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(extent));
  endfunction

  // Mouse motion: half of it small so the cursor wanders instead of pinning to an edge.
  function automatic logic [15:0] pick_motion();
    if ($urandom_range(1) == 0) return 16'($urandom);
    return 16'($urandom_range(128)) - 16'd64;
  endfunction

  function automatic logic [15:0] pick_divisor();
    case ($urandom_range(19))
      0:          return 16'd0;
      1:          return 16'hFFFF;
      2, 3, 4, 5,
      6, 7, 8, 9: return 16'($urandom_range(8, 1));
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'd1;
      2:       return 12'd4095;
      default: return 12'($urandom_range(4095, 1));
    endcase
  endfunction

  // Every field gets random content whatever the command, so unused fields are noise.
  function automatic logic [PCT_IN_DATA_BITS-1:0] random_report();
    logic [15:0] amx, amy;
    amx = pick_extent();
    amy = pick_extent();
    return pack_report(pick_coord(amx), pick_coord(amy), amx, amy, 1'($urandom),
                       pick_motion(), pick_motion(), pick_divisor(), pick_divisor(),
                       1'($urandom));
  endfunction

  // Presents one report request and returns at the falling edge after it is taken, with
  // tvalid still high so a back-to-back request needs no second assignment.
  task automatic send_report(input cmd_t cmd, input logic [PCT_IN_DATA_BITS-1:0] data);
    while (!calm && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_by_cmd[cmd]++;
  endtask

  // Leaves psel high so that a following write starts without a second assignment.
  task automatic write_reg(input reg_idx_t idx, input logic [PCT_APB_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // Random upper bits check that the block keeps only the register's own width.
  task automatic set_config(input logic [11:0] w, input logic [11:0] h,
                            input logic [7:0] gain, input logic avail);
    write_reg(REG_WIDTH,  {20'($urandom), w});
    write_reg(REG_HEIGHT, {20'($urandom), h});
    write_reg(REG_SPEED,  {24'($urandom), gain});
    write_reg(REG_AVAIL,  {31'($urandom), avail});
    psel    <= 1'b0;
    penable <= 1'b0;
    ptr_on   = avail;
    settings_made++;
  endtask

  // Registers change only with nothing in flight. Every request yields a result, so once
  // the checker has nothing outstanding the block is idle; a few cycles more cost nothing.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int         item_goal;
    int         pick;
    cmd_t       cmd;
    rst           = 1'b1;
    calm          = 1'b0;
    ptr_on        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_NONE;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset there is no pointer: reports leave everything frozen with status
    // not ready, while recenter still goes through.
    send_report(CMD_NONE, random_report());
    send_report(CMD_ABS, pack_report(16'd100, 16'd100, 16'd200, 16'd200, 1'b1,
                                     16'd0, 16'd0, 16'd1, 16'd1, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'd50, 16'd50, 16'd1, 16'd1, 1'b1));
    send_report(CMD_RECENTER, random_report());
    wait_drained();

    set_config(12'd1024, 12'd768, 8'd4, 1'b1);
    // Touch at full scale saturates to the right edge; y at zero; touch is held.
    send_report(CMD_ABS, pack_report(16'hFFFF, 16'd0, 16'hFFFF, 16'd100, 1'b1,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    // Zero extent on x gives zero, a coordinate beyond the extent on y saturates, and
    // lifting the touch raises press.
    send_report(CMD_ABS, pack_report(16'd70, 16'hFFFF, 16'd0, 16'd1, 1'b0,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    // A round with no report clears press and keeps the rest.
    send_report(CMD_NONE, random_report());
    // Largest motion both ways with unit resolution clamps to both edges.
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'h7FFF, 16'h8000, 16'd1, 16'd1, 1'b1));
    // Small moves: negative quotients truncate toward zero; button release is a press.
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     -16'sd5, 16'd7, 16'd2, 16'd3, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     -16'sd7, 16'd300, 16'd3, 16'd0, 1'b1));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // Recenter while the button is held clears both flags.
    send_report(CMD_RECENTER, random_report());
    // Touch then release, so press is set when the pointer goes away.
    send_report(CMD_ABS, pack_report(16'd10, 16'd10, 16'd20, 16'd20, 1'b1,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_report(CMD_ABS, pack_report(16'd5, 16'd15, 16'd20, 16'd20, 1'b0,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    wait_drained();

    // Without a pointer the old press value must stick.
    set_config(12'd1024, 12'd768, 8'd4, 1'b0);
    send_report(CMD_NONE, random_report());
    send_report(CMD_REL, random_report());
    wait_drained();

    // Largest screen and gain.
    set_config(12'd4095, 12'd4095, 8'd255, 1'b1);
    send_report(CMD_ABS, pack_report(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 1'b1,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'h7FFF, 16'h8000, 16'd1, 16'd1, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'h8000, 16'h7FFF, 16'd1, 16'd1, 1'b1));
    send_report(CMD_RECENTER, random_report());
    wait_drained();

    // Single-pixel screen and zero gain: every move stays at zero.
    set_config(12'd1, 12'd1, 8'd0, 1'b1);
    send_report(CMD_ABS, pack_report(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 1'b1,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'h7FFF, 16'h7FFF, 16'd1, 16'd1, 1'b0));
    send_report(CMD_RECENTER, random_report());
    wait_drained();

    // Zero-sized screen: the only coordinate left is zero.
    set_config(12'd0, 12'd0, 8'd255, 1'b1);
    send_report(CMD_ABS, pack_report(16'd5, 16'd9, 16'd10, 16'd10, 1'b1,
                                     16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_report(CMD_REL, pack_report(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
                                     16'd100, 16'h8000, 16'd1, 16'd1, 1'b0));
    send_report(CMD_RECENTER, random_report());
    wait_drained();

    // Random phases, each under its own register setting. The first two pin the extremes,
    // one phase runs with no idle cycles on either side, and pointer-less phases are kept
    // short since only recenter changes the state in them.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_config(12'd4095, 12'd4095, 8'd255, 1'b1);
        1:       set_config(12'd1, 12'd1, 8'd0, 1'b1);
        default: set_config(pick_size(), pick_size(),
                            ($urandom_range(4) == 0) ? 8'($urandom_range(1) * 255)
                                                     : 8'($urandom),
                            $urandom_range(99) < 85);
      endcase
      calm      = (phase == 4);
      item_goal = ptr_on ? 220 : 40;
      for (int n = 0; n < item_goal; n++) begin
        pick = $urandom_range(99);
        if (pick < 15)      cmd = CMD_NONE;
        else if (pick < 50) cmd = CMD_ABS;
        else if (pick < 90) cmd = CMD_REL;
        else                cmd = CMD_RECENTER;
        send_report(cmd, random_report());
      end
      wait_drained();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d reports (none %0d, absolute %0d, relative %0d, recenter %0d)",
             sent_by_cmd[CMD_NONE] + sent_by_cmd[CMD_ABS] + sent_by_cmd[CMD_REL] +
             sent_by_cmd[CMD_RECENTER], sent_by_cmd[CMD_NONE], sent_by_cmd[CMD_ABS],
             sent_by_cmd[CMD_REL], sent_by_cmd[CMD_RECENTER]);
    $display("under %0d register settings; %0d results checked, %0d mismatches.",
             settings_made, results_taken, errors);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
